// ===== sv/homogeneous_point_transform_assert.svh =====
// Assertion macros for the homogeneous point transform.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define HPT_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define HPT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define HPT_ASSERT_SAME(label, pre, post)
`define HPT_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== sv/hpt_pkg.sv =====
// Package for the homogeneous point transform: widths, divider stage type and helpers.
// No dependencies.
`default_nettype none
package hpt_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_REGS   = 8;
	localparam int SUM_W      = 64 - FRAC_BITS + 3;
	localparam int NUM_W      = 32 + FRAC_BITS;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int QUO_W      = DIV_STAGES * DIV_BITS;
	localparam logic [SUM_W-1:0] FIX_ONE = SUM_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [31:0] val;
		logic        clip;
	} hpt_sat_t;

	typedef struct packed {
		logic                    need_div;
		logic                    wzero;
		logic                    sat;
		logic [2:0][31:0]        t;
		logic [2:0][QUO_W-1:0]   dvd;
		logic [2:0][31:0]        rem;
		logic [2:0][QUO_W-1:0]   quo;
		logic [2:0]              qneg;
		logic [31:0]             dmag;
	} hpt_div_t;

	function automatic hpt_sat_t sat32(input logic [SUM_W-1:0] v);
		hpt_sat_t r;
		r.clip = !((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]));
		r.val  = r.clip ? (v[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff) : v[31:0];
		return r;
	endfunction

	function automatic hpt_div_t div_step(input hpt_div_t a);
		hpt_div_t   r;
		logic [32:0] trial;
		r = a;
		for (int l = 0; l < 3; l++) begin
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {r.rem[l], r.dvd[l][QUO_W-1]};
				r.dvd[l] = {r.dvd[l][QUO_W-2:0], 1'b0};
				if (trial >= {1'b0, r.dmag}) begin
					trial = trial - {1'b0, r.dmag};
					r.quo[l] = {r.quo[l][QUO_W-2:0], 1'b1};
				end else begin
					r.quo[l] = {r.quo[l][QUO_W-2:0], 1'b0};
				end
				r.rem[l] = trial[31:0];
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/homogeneous_point_transform.sv =====
// Throughput one transaction a cycle while the output is not stalled.
// Three arithmetic stages (products, row sums, saturation) feed a divider that resolves four
// quotient bits per stage, then an output register. A stall on the output freezes every stage.
// Reset is asynchronous and active low: it clears all valid bits and loads the identity matrix.
// Depends on hpt_pkg and homogeneous_point_transform_assert.svh.
`default_nettype none
`include "homogeneous_point_transform_assert.svh"
module homogeneous_point_transform (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,  // in_x, in_y, in_z
	input  wire logic         s_axis_tuser,  // op
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,  // out_x, out_y, out_z
	output logic [1:0]        m_axis_tuser,  // w_was_zero, saturated
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	localparam int DS = hpt_pkg::DIV_STAGES;

	logic [63:0]                      matrix_q [hpt_pkg::NUM_REGS];
	logic                             en;
	logic signed [31:0]               elem [4][4];

	logic                             valid_s1;
	logic                             point_s1;
	logic signed [63:0]               prod_s1 [4][3];

	logic                             valid_s2;
	logic                             point_s2;
	logic [hpt_pkg::SUM_W-1:0]        sum_s2 [4];

	logic                             valid_s3;
	hpt_pkg::hpt_div_t                div_s3;
	hpt_pkg::hpt_div_t                div_in;

	logic                             dvalid_s [DS];
	hpt_pkg::hpt_div_t                dstage_s [DS];

	logic                             out_valid_q;
	logic [95:0]                      out_data_q;
	logic [1:0]                       out_user_q;
	logic [95:0]                      fin_data;
	logic                             fin_clip;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en && arst_n;
	assign cfg_ready     = arst_n;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q[0] <= 64'd65536;
			matrix_q[1] <= 64'd0;
			matrix_q[2] <= 64'd65536 << 32;
			matrix_q[3] <= 64'd0;
			matrix_q[4] <= 64'd0;
			matrix_q[5] <= 64'd65536;
			matrix_q[6] <= 64'd0;
			matrix_q[7] <= 64'd65536 << 32;
		end else if (cfg_valid) begin
			matrix_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				elem[r][c] = matrix_q[r * 2 + c / 2][(c % 2) * 32 +: 32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < DS; k++) begin
				dvalid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s1    <= s_axis_tvalid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			dvalid_s[0] <= valid_s3;
			for (int k = 1; k < DS; k++) begin
				dvalid_s[k] <= dvalid_s[k-1];
			end
			out_valid_q <= dvalid_s[DS-1];
		end
	end

	always_comb begin
		hpt_pkg::hpt_sat_t ts;
		hpt_pkg::hpt_sat_t ws;
		logic              wz;
		logic              wone;
		logic [31:0]       mag;
		div_in = '0;
		ws   = hpt_pkg::sat32(sum_s2[3]);
		wz   = (sum_s2[3] == '0);
		wone = (sum_s2[3] == hpt_pkg::FIX_ONE);
		div_in.need_div = point_s2 && !wz && !wone;
		div_in.wzero    = point_s2 && wz;
		div_in.dmag     = ws.val[31] ? (~ws.val + 32'd1) : ws.val;
		div_in.sat      = div_in.need_div && ws.clip;
		for (int l = 0; l < 3; l++) begin
			ts = hpt_pkg::sat32(sum_s2[l]);
			div_in.t[l]    = ts.val;
			div_in.sat     = div_in.sat || ts.clip;
			mag            = ts.val[31] ? (~ts.val + 32'd1) : ts.val;
			div_in.dvd[l]  = hpt_pkg::QUO_W'({mag, hpt_pkg::FRAC_BITS'(0)});
			div_in.qneg[l] = ts.val[31] ^ ws.val[31];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_s1 <= !s_axis_tuser;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(s_axis_tdata[c * 32 +: 32]) * elem[r][c];
				end
			end
			point_s2 <= point_s1;
			for (int r = 0; r < 4; r++) begin
				sum_s2[r] <= hpt_pkg::SUM_W'(prod_s1[r][0] >>> hpt_pkg::FRAC_BITS)
					+ hpt_pkg::SUM_W'(prod_s1[r][1] >>> hpt_pkg::FRAC_BITS)
					+ hpt_pkg::SUM_W'(prod_s1[r][2] >>> hpt_pkg::FRAC_BITS)
					+ (point_s1 ? hpt_pkg::SUM_W'(elem[r][3]) : '0);
			end
			div_s3      <= div_in;
			dstage_s[0] <= hpt_pkg::div_step(div_s3);
			for (int k = 1; k < DS; k++) begin
				dstage_s[k] <= hpt_pkg::div_step(dstage_s[k-1]);
			end
			out_data_q <= dstage_s[DS-1].need_div ? fin_data
				: {dstage_s[DS-1].t[2], dstage_s[DS-1].t[1], dstage_s[DS-1].t[0]};
			out_user_q <= {dstage_s[DS-1].sat || (dstage_s[DS-1].need_div && fin_clip),
				dstage_s[DS-1].wzero};
		end
	end

	always_comb begin
		logic [hpt_pkg::QUO_W-1:0] mag;
		logic                      clip;
		logic                      neg;
		fin_clip = 1'b0;
		fin_data = '0;
		for (int l = 0; l < 3; l++) begin
			mag  = dstage_s[DS-1].quo[l];
			neg  = dstage_s[DS-1].qneg[l];
			clip = neg ? (mag > hpt_pkg::QUO_W'(33'h0_8000_0000))
				: (mag > hpt_pkg::QUO_W'(33'h0_7fff_ffff));
			fin_clip = fin_clip || clip;
			if (clip) begin
				fin_data[l * 32 +: 32] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				fin_data[l * 32 +: 32] = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
			end
		end
	end

	`HPT_ASSERT_SAME(a_div_nonzero, valid_s3 && div_s3.need_div, div_s3.dmag != 32'd0)
	`HPT_ASSERT_NEXT(a_stall_holds, valid_s1 && !en, valid_s1)
	`HPT_ASSERT_NEXT(a_drain_out, en && dvalid_s[DS-1], out_valid_q)
	`HPT_ASSERT_SAME(a_wzero_nodiv, valid_s3 && div_s3.wzero, !div_s3.need_div)
endmodule
`default_nettype wire
